@@ rtl/alert_tone_sequencer_core_defines.svh @@
// Assertion helpers shared by the RTL; clk and rst_n must be in scope.
`ifndef ALERT_TONE_SEQUENCER_CORE_DEFINES_SVH
`define ALERT_TONE_SEQUENCER_CORE_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define ATS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ats_pkg.sv @@
`default_nettype none

package ats_pkg;

  // input function codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_REQUEST = 2'd1;
  localparam logic [1:0] FUNC_SILENCE = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  // alert codes
  localparam logic [2:0] ALERT_NONE      = 3'd0;
  localparam logic [2:0] ALERT_START     = 3'd1;
  localparam logic [2:0] ALERT_HOMED     = 3'd2;
  localparam logic [2:0] ALERT_STOP      = 3'd3;
  localparam logic [2:0] ALERT_BEEPS     = 3'd4;
  localparam logic [2:0] ALERT_CRESCENDO = 3'd5;

  // tones
  localparam logic [1:0] TONE_C7 = 2'd0;
  localparam logic [1:0] TONE_E7 = 2'd1;
  localparam logic [1:0] TONE_G7 = 2'd2;
  localparam logic [1:0] TONE_C8 = 2'd3;

  // volumes in tenths
  localparam logic [3:0] VOL_OFF  = 4'd0;
  localparam logic [3:0] VOL_LOW  = 4'd4;
  localparam logic [3:0] VOL_MID  = 4'd6;
  localparam logic [3:0] VOL_HIGH = 4'd8;
  localparam logic [3:0] VOL_FULL = 4'd10;

  // timing in ms
  localparam logic [15:0] NOTE1_MS    = 16'd100;
  localparam logic [15:0] NOTE2_MS    = 16'd200;
  localparam logic [15:0] NOTE3_MS    = 16'd300;
  localparam logic [15:0] NOTE4_MS    = 16'd400;
  localparam logic [15:0] BEEP_ON_MS  = 16'd250;
  localparam logic [15:0] BEEP_END_MS = 16'd500;
  localparam logic [15:0] CRESC1_MS   = 16'd5000;
  localparam logic [15:0] CRESC2_MS   = 16'd10000;
  localparam logic [15:0] CRESC3_MS   = 16'd15000;
  localparam logic [15:0] CRESC4_MS   = 16'd20000;

  localparam logic [15:0] ALERT_MAX_MS   = 16'hFFFF;
  localparam logic [16:0] SILENCE_MAX_MS = 17'h1FFFF;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_SILENCE_LIMIT = 1'b0;  // register index, paddr[2]
  localparam logic [16:0] SILENCE_LIMIT_RST = 17'd60000;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] alert_code;
  } in_beat_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [1:0] tone_select;
    logic [3:0] volume_tenths;
    logic       alert_active;
    logic [2:0] active_alert;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]  held_alert;
    logic        in_progress;
    logic [15:0] alert_elapsed_ms;
    logic        silenced;
    logic [16:0] silence_elapsed_ms;
    logic        drive_on;
    logic [1:0]  drive_tone;
    logic [3:0]  drive_volume;
  } ats_state_t;

endpackage

`default_nettype wire

@@ rtl/ats_cfg.sv @@
`default_nettype none

module ats_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ats_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ats_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [ats_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [16:0]                     silence_limit
);

  logic [16:0] silence_limit_r;
  logic [16:0] silence_limit_nxt;
  logic        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready
                  && (paddr[2] == ats_pkg::REG_SILENCE_LIMIT);

  always_comb begin
    silence_limit_nxt = silence_limit_r;
    if (wr_hit) begin
      silence_limit_nxt = pwdata[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_limit_r <= ats_pkg::SILENCE_LIMIT_RST;
    end else begin
      silence_limit_r <= silence_limit_nxt;
    end
  end

  // reads beyond the map return zero; low address bits ignored
  always_comb begin
    prdata = '0;
    if (paddr[2] == ats_pkg::REG_SILENCE_LIMIT) begin
      prdata = {{(ats_pkg::CFG_DATA_W-17){1'b0}}, silence_limit_r};
    end
  end

  assign silence_limit = silence_limit_r;

endmodule

`default_nettype wire

@@ rtl/ats_step.sv @@
`default_nettype none

module ats_step (
  input  wire ats_pkg::ats_state_t cur,
  input  wire ats_pkg::in_beat_t   item,
  input  wire logic [16:0]         silence_limit,
  output ats_pkg::ats_state_t      nxt,
  output ats_pkg::out_beat_t       result
);

  logic [15:0] t;
  logic [16:0] sil_t;
  logic [1:0]  note;
  logic        take_req;

  // note index for the four-note patterns (t / 100 below 400)
  always_comb begin
    if (t < ats_pkg::NOTE1_MS) begin
      note = 2'd0;
    end else if (t < ats_pkg::NOTE2_MS) begin
      note = 2'd1;
    end else if (t < ats_pkg::NOTE3_MS) begin
      note = 2'd2;
    end else begin
      note = 2'd3;
    end
  end

  assign take_req = (item.alert_code <= ats_pkg::ALERT_CRESCENDO)
                    && ((item.alert_code == ats_pkg::ALERT_NONE) || !cur.in_progress
                        || (item.alert_code > cur.held_alert));

  always_comb begin
    nxt   = cur;
    t     = cur.alert_elapsed_ms;
    sil_t = cur.silence_elapsed_ms;
    case (item.func)
      ats_pkg::FUNC_TICK: begin
        if (cur.in_progress && (t != ats_pkg::ALERT_MAX_MS)) begin
          t = t + 16'd1;
        end
        if (sil_t != ats_pkg::SILENCE_MAX_MS) begin
          sil_t = sil_t + 17'd1;
        end
        nxt.alert_elapsed_ms   = t;
        nxt.silence_elapsed_ms = sil_t;
        if (cur.in_progress) begin
          case (cur.held_alert)
            ats_pkg::ALERT_NONE: begin
              nxt.drive_on         = 1'b0;
              nxt.in_progress      = 1'b0;
              nxt.alert_elapsed_ms = '0;
            end
            ats_pkg::ALERT_START, ats_pkg::ALERT_STOP: begin
              nxt.drive_volume = ats_pkg::VOL_HIGH;
              nxt.drive_on     = 1'b1;
              if (t < ats_pkg::NOTE4_MS) begin
                nxt.drive_tone = (cur.held_alert == ats_pkg::ALERT_START) ? note : ~note;
              end else begin
                nxt.drive_on         = 1'b0;
                nxt.in_progress      = 1'b0;
                nxt.alert_elapsed_ms = '0;
              end
            end
            ats_pkg::ALERT_HOMED: begin
              nxt.drive_volume = ats_pkg::VOL_HIGH;
              nxt.drive_on     = 1'b1;
              if (t < ats_pkg::NOTE1_MS) begin
                nxt.drive_tone = ats_pkg::TONE_C7;
              end else begin
                nxt.drive_on         = 1'b0;
                nxt.in_progress      = 1'b0;
                nxt.alert_elapsed_ms = '0;
              end
            end
            ats_pkg::ALERT_BEEPS: begin
              if (cur.silenced) begin
                nxt.drive_on = 1'b0;
              end else if (t < ats_pkg::BEEP_ON_MS) begin
                nxt.drive_volume = ats_pkg::VOL_HIGH;
                nxt.drive_on     = 1'b1;
                nxt.drive_tone   = ats_pkg::TONE_C7;
              end else if (t < ats_pkg::BEEP_END_MS) begin
                nxt.drive_volume = ats_pkg::VOL_OFF;
                nxt.drive_on     = 1'b0;
              end else begin
                nxt.alert_elapsed_ms = '0;
              end
            end
            ats_pkg::ALERT_CRESCENDO: begin
              if (cur.silenced) begin
                nxt.drive_on = 1'b0;
              end else if (t < ats_pkg::CRESC4_MS) begin
                nxt.drive_on   = 1'b1;
                nxt.drive_tone = ats_pkg::TONE_E7;
                if (t < ats_pkg::CRESC1_MS) begin
                  nxt.drive_volume = ats_pkg::VOL_LOW;
                end else if (t < ats_pkg::CRESC2_MS) begin
                  nxt.drive_volume = ats_pkg::VOL_MID;
                end else if (t < ats_pkg::CRESC3_MS) begin
                  nxt.drive_volume = ats_pkg::VOL_HIGH;
                end else begin
                  nxt.drive_volume = ats_pkg::VOL_FULL;
                end
              end
            end
            default: begin
            end
          endcase
        end
        // pattern above sees the old silence flag
        if (cur.silenced && (sil_t > silence_limit)) begin
          nxt.silenced = 1'b0;
        end
      end
      ats_pkg::FUNC_REQUEST: begin
        if (take_req) begin
          nxt.held_alert       = item.alert_code;
          nxt.in_progress      = 1'b1;
          nxt.alert_elapsed_ms = '0;
        end
      end
      ats_pkg::FUNC_SILENCE: begin
        nxt.silenced           = 1'b1;
        nxt.silence_elapsed_ms = '0;
      end
      default: begin
      end
    endcase
  end

  assign result = '{buzzer_on:     nxt.drive_on,
                    tone_select:   nxt.drive_tone,
                    volume_tenths: nxt.drive_volume,
                    alert_active:  nxt.in_progress,
                    active_alert:  nxt.held_alert};

endmodule

`default_nettype wire

@@ rtl/alert_tone_sequencer_core.sv @@
// Alert tone sequencer: plays timed buzzer patterns from a 1 ms tick.
// Input channel (in_valid / in_stall / in_data): one beat is a tick, an
//   alert request or a silence command; every beat yields one result beat.
// Result channel (out_valid / out_stall / out_data): buzzer on/off, tone,
//   volume in tenths, alert-in-progress flag and held alert code, as the
//   state stands after the beat.
// Configuration: APB-style, one register (silence limit, ms) at byte 0;
//   pready is tied high, writes land on the access cycle.
// Path: a beat taken into the input register passes through the step logic
//   and lands in the result register once that is free; out_valid rises
//   on the same edge that loads the result register.
// Throughput: one beat per cycle unless stalled, set by the single input
//   register feeding the result register, alert state updated on the same edge.
// Stall: while out_stall holds a waiting result the input register still
//   fills once, after which in_stall rises; no beat is lost or reordered.
// Reset (rst_n low, synchronous): no alert, counters cleared, buzzer off,
//   silence limit back to 60000 ms; both valids drop.
`default_nettype none
`include "alert_tone_sequencer_core_defines.svh"

module alert_tone_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ats_pkg::in_beat_t               in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ats_pkg::out_beat_t                   out_data,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ats_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ats_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [ats_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  // input register
  logic                in_valid_r, in_valid_nxt;
  ats_pkg::in_beat_t   in_data_r;
  // result register
  logic                out_valid_r, out_valid_nxt;
  ats_pkg::out_beat_t  out_data_r;
  // alert state
  ats_pkg::ats_state_t state_r, state_nxt;

  ats_pkg::out_beat_t  step_result;
  logic [16:0]         silence_limit;
  logic                advance;

  ats_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .silence_limit (silence_limit)
  );

  ats_step u_step (
    .cur           (state_r),
    .item          (in_data_r),
    .silence_limit (silence_limit),
    .nxt           (state_nxt),
    .result        (step_result)
  );

  // beat moves from input to result register when the latter is free
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // elapsed counter only runs while an alert is in progress
  `ATS_ASSERT_ALWAYS(a_idle_elapsed_zero, (state_r.in_progress || state_r.alert_elapsed_ms == 16'd0), "elapsed counter non-zero with no alert")
  `ATS_ASSERT_ALWAYS(a_volume_range, (state_r.drive_volume <= ats_pkg::VOL_FULL), "volume above full scale")
  `ATS_ASSERT_ALWAYS(a_held_code_range, (state_r.held_alert <= ats_pkg::ALERT_CRESCENDO), "held alert code out of range")
  `ATS_ASSERT_NEXT(a_blocked_beat_kept, (in_valid_r && !advance), (in_valid_r && $stable(in_data_r) && $stable(state_r)), "blocked beat lost or state moved")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;

  // Expected-drive tracker: mirrors the sequencer state, queues the result
  // beat each accepted input beat should produce and checks what comes out.
  class buzzer_tracker;
    logic [16:0]        mute_limit;
    logic [2:0]         held;
    bit                 busy;
    logic [15:0]        alert_ms;
    bit                 muted;
    logic [16:0]        mute_ms;
    bit                 on;
    logic [1:0]         tone;
    logic [3:0]         vol;
    ats_pkg::out_beat_t drive_due[$];
    int                 errors;

    function new();
      mute_limit = ats_pkg::SILENCE_LIMIT_RST;
      held       = ats_pkg::ALERT_NONE;
      busy       = 1'b0;
      alert_ms   = '0;
      muted      = 1'b0;
      mute_ms    = '0;
      on         = 1'b0;
      tone       = ats_pkg::TONE_C7;
      vol        = ats_pkg::VOL_OFF;
      errors     = 0;
    endfunction

    function void finish_alert();
      on       = 1'b0;
      busy     = 1'b0;
      alert_ms = '0;
    endfunction

    function void four_notes(bit rising);
      logic [1:0] idx;
      vol = ats_pkg::VOL_HIGH;
      on  = 1'b1;
      if (alert_ms < ats_pkg::NOTE4_MS) begin
        if (alert_ms < ats_pkg::NOTE1_MS) idx = 2'd0;
        else if (alert_ms < ats_pkg::NOTE2_MS) idx = 2'd1;
        else if (alert_ms < ats_pkg::NOTE3_MS) idx = 2'd2;
        else idx = 2'd3;
        tone = rising ? idx : ~idx;
      end else begin
        finish_alert();
      end
    endfunction

    function void play_pattern();
      case (held)
        ats_pkg::ALERT_NONE: begin
          finish_alert();
        end
        ats_pkg::ALERT_START: begin
          four_notes(1'b1);
        end
        ats_pkg::ALERT_HOMED: begin
          vol = ats_pkg::VOL_HIGH;
          on  = 1'b1;
          if (alert_ms < ats_pkg::NOTE1_MS) tone = ats_pkg::TONE_C7;
          else finish_alert();
        end
        ats_pkg::ALERT_STOP: begin
          four_notes(1'b0);
        end
        ats_pkg::ALERT_BEEPS: begin
          if (muted) begin
            on = 1'b0;
          end else if (alert_ms < ats_pkg::BEEP_ON_MS) begin
            vol  = ats_pkg::VOL_HIGH;
            on   = 1'b1;
            tone = ats_pkg::TONE_C7;
          end else if (alert_ms < ats_pkg::BEEP_END_MS) begin
            vol = ats_pkg::VOL_OFF;
            on  = 1'b0;
          end else begin
            alert_ms = '0;
          end
        end
        ats_pkg::ALERT_CRESCENDO: begin
          if (muted) begin
            on = 1'b0;
          end else if (alert_ms < ats_pkg::CRESC4_MS) begin
            if (alert_ms < ats_pkg::CRESC1_MS) vol = ats_pkg::VOL_LOW;
            else if (alert_ms < ats_pkg::CRESC2_MS) vol = ats_pkg::VOL_MID;
            else if (alert_ms < ats_pkg::CRESC3_MS) vol = ats_pkg::VOL_HIGH;
            else vol = ats_pkg::VOL_FULL;
            on   = 1'b1;
            tone = ats_pkg::TONE_E7;
          end
        end
        default: ;
      endcase
    endfunction

    // Advance the mirror by one accepted input beat and queue its result.
    function void take_beat(ats_pkg::in_beat_t b);
      ats_pkg::out_beat_t e;
      case (b.func)
        ats_pkg::FUNC_TICK: begin
          if (busy && alert_ms < ats_pkg::ALERT_MAX_MS) alert_ms++;
          if (mute_ms < ats_pkg::SILENCE_MAX_MS) mute_ms++;
          if (busy) play_pattern();
          if (muted && mute_ms > mute_limit) muted = 1'b0;
        end
        ats_pkg::FUNC_REQUEST: begin
          if (b.alert_code <= ats_pkg::ALERT_CRESCENDO &&
              (b.alert_code == ats_pkg::ALERT_NONE || !busy || b.alert_code > held)) begin
            held     = b.alert_code;
            busy     = 1'b1;
            alert_ms = '0;
          end
        end
        ats_pkg::FUNC_SILENCE: begin
          muted   = 1'b1;
          mute_ms = '0;
        end
        default: ;
      endcase
      e.buzzer_on     = on;
      e.tone_select   = tone;
      e.volume_tenths = vol;
      e.alert_active  = busy;
      e.active_alert  = held;
      drive_due.push_back(e);
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, what, exp_v, got_v);
    endfunction

    function void check_drive(ats_pkg::out_beat_t got);
      ats_pkg::out_beat_t e;
      if (drive_due.size() == 0) begin
        flag("result beat with nothing due", 32'd0, 32'(got));
        return;
      end
      e = drive_due.pop_front();
      if (got.buzzer_on !== e.buzzer_on)
        flag("buzzer_on", 32'(e.buzzer_on), 32'(got.buzzer_on));
      if (got.tone_select !== e.tone_select)
        flag("tone_select", 32'(e.tone_select), 32'(got.tone_select));
      if (got.volume_tenths !== e.volume_tenths)
        flag("volume_tenths", 32'(e.volume_tenths), 32'(got.volume_tenths));
      if (got.alert_active !== e.alert_active)
        flag("alert_active", 32'(e.alert_active), 32'(got.alert_active));
      if (got.active_alert !== e.active_alert)
        flag("active_alert", 32'(e.active_alert), 32'(got.active_alert));
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  ats_pkg::in_beat_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ats_pkg::out_beat_t             out_data;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [ats_pkg::CFG_ADDR_W-1:0] paddr     = '0;
  logic [ats_pkg::CFG_DATA_W-1:0] pwdata    = '0;
  logic [ats_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  buzzer_tracker tracker = new();

  // Shared knobs: idle_on gates random gaps/stalls on both sides; hold_req
  // asks the receiver for one long hold-off.
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int useful   = 0;    // accepted beats other than no-ops and out-of-range requests

  alert_tone_sequencer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side. Values read straight after the edge are the pre-edge ones,
  // so a beat counts when out_valid was high and our stall was low.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.check_drive(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        // long hold-off: the block must back up and stall its input
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 25);
      end
    end
  end

  // Offer one beat, with optional random gaps first; returns at the edge
  // that takes it. Valid is not dropped between back-to-back beats.
  task automatic send_beat(input logic [1:0] f, input logic [2:0] c);
    ats_pkg::in_beat_t b;
    b.func       = f;
    b.alert_code = c;
    while (idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_beat(b);
    if (f != ats_pkg::FUNC_NOP && !(f == ats_pkg::FUNC_REQUEST && c > ats_pkg::ALERT_CRESCENDO))
      useful++;
  endtask

  // alert_code is a don't-care on ticks, so it is randomised there
  task automatic tick_run(input int n);
    repeat (n) send_beat(ats_pkg::FUNC_TICK, 3'($urandom_range(0, 7)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.drive_due.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; lands on the access edge.
  task automatic write_limit(input logic [16:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ats_pkg::REG_SILENCE_LIMIT, 2'b00};
    pwdata  <= ats_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.mute_limit = v;
  endtask

  // Mostly well-formed: a request followed by a tick run with the odd
  // silence, request or no-op mixed in. The rest is short random noise.
  task automatic random_burst();
    int n;
    int r;
    if ($urandom_range(0, 99) < 70) begin
      if ($urandom_range(0, 99) < 90)
        send_beat(ats_pkg::FUNC_REQUEST,
                  3'($urandom_range(ats_pkg::ALERT_NONE, ats_pkg::ALERT_CRESCENDO)));
      else
        send_beat(ats_pkg::FUNC_REQUEST, 3'($urandom_range(6, 7)));
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 40) : $urandom_range(100, 260);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_beat(ats_pkg::FUNC_SILENCE, 3'($urandom_range(0, 7)));
        else if (r < 5) send_beat(ats_pkg::FUNC_REQUEST, 3'($urandom_range(0, 7)));
        else if (r < 6) send_beat(ats_pkg::FUNC_NOP, 3'($urandom_range(0, 7)));
        else send_beat(ats_pkg::FUNC_TICK, 3'($urandom_range(0, 7)));
      end
    end else begin
      repeat ($urandom_range(1, 12))
        send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no-op, ignored codes, priority of replacement, "none"
    // overriding anything, silence twice in a row, muted beeping.
    send_beat(ats_pkg::FUNC_NOP, 3'd7);
    send_beat(ats_pkg::FUNC_TICK, ats_pkg::ALERT_NONE);
    send_beat(ats_pkg::FUNC_REQUEST, 3'd6);
    send_beat(ats_pkg::FUNC_REQUEST, 3'd7);
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_START);
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_HOMED);
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_START);     // lower code, ignored
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_STOP);
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_BEEPS);
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_CRESCENDO);
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_BEEPS);     // lower code, ignored
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_NONE);      // always replaces
    send_beat(ats_pkg::FUNC_TICK, 3'd7);
    send_beat(ats_pkg::FUNC_TICK, ats_pkg::ALERT_NONE);
    send_beat(ats_pkg::FUNC_SILENCE, ats_pkg::ALERT_NONE);
    send_beat(ats_pkg::FUNC_SILENCE, 3'd7);                     // restarts the silence count
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_BEEPS);
    send_beat(ats_pkg::FUNC_TICK, ats_pkg::ALERT_NONE);         // muted beep
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_NONE);
    send_beat(ats_pkg::FUNC_TICK, ats_pkg::ALERT_NONE);
    send_beat(ats_pkg::FUNC_NOP, ats_pkg::ALERT_NONE);

    // Pattern sweeps, no idling at all, zero silence limit.
    wait_drained();
    write_limit('0);
    idle_on = 1'b0;
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_START);
    tick_run(402);                            // all rising notes, then the end
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_HOMED);
    tick_run(102);
    send_beat(ats_pkg::FUNC_REQUEST, ats_pkg::ALERT_BEEPS);
    tick_run(30);
    send_beat(ats_pkg::FUNC_SILENCE, ats_pkg::ALERT_NONE);
    tick_run(5);                              // silence gone after one tick
    idle_on = 1'b1;

    // Random part, first half with a long receiver hold-off and a short
    // silence limit; then a pause for everything to drain.
    wait_drained();
    write_limit(17'($urandom_range(0, 300)));
    hold_req = 1'b1;
    useful   = 0;
    while (useful < 70) random_burst();
    wait_drained();
    write_limit(17'($urandom_range(0, 131071)));
    while (useful < 140) random_burst();

    // Drain, let any stray beats come out of the pipe, then judge.
    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.drive_due.size() != 0)
      tracker.flag("result beats still due", 32'd0, 32'(tracker.drive_due.size()));
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ alert_tone_sequencer_core.f @@
+incdir+rtl
rtl/ats_pkg.sv
rtl/ats_cfg.sv
rtl/ats_step.sv
rtl/alert_tone_sequencer_core.sv
tb/sv/tb.sv
